// File: rtl/core/ppg_pkg.sv
`timescale 1ns / 1ps

package ppg_pkg;

	localparam int PHASE_W   = 8;
	localparam int LEVEL_W   = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 48;
	localparam int NUM_CHAN  = 3;
	localparam int NUM_PHASE = 2 * NUM_CHAN;

	// Request codes carried in req_type.
	localparam logic [1:0] REQ_PIXEL  = 2'd0;
	localparam logic [1:0] REQ_FRAME  = 2'd1;
	localparam logic [1:0] REQ_RELOAD = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_COORD_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEPS = 2'd2;

	localparam logic [7:0]       SCALE_RESET = 8'd1;
	localparam logic [CFG_W-1:0] START_RESET = 48'h0;
	localparam logic [CFG_W-1:0] STEPS_RESET = 48'h0404_0404_0404;

	// A step of this value leaves a phase where it is.
	localparam logic [PHASE_W-1:0] STEP_REST = 8'd4;
	localparam logic [PHASE_W-1:0] QUARTER   = 8'd64;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
	} in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
	} out_t;

	typedef logic [PHASE_W-1:0] phase_t;

	localparam logic [7:0] HALF_WAVE [128] = '{
		8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253,
		8'd253, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd246,
		8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235,
		8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
		8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203, 8'd201,
		8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185, 8'd182, 8'd179,
		8'd176, 8'd173, 8'd170, 8'd167, 8'd165, 8'd162, 8'd158, 8'd155,
		8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
		8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
		8'd103, 8'd100, 8'd97,  8'd93,  8'd90,  8'd88,  8'd85,  8'd82,
		8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd65,  8'd62,  8'd59,
		8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd44,  8'd42,  8'd40,
		8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
		8'd21,  8'd20,  8'd18,  8'd17,  8'd15,  8'd14,  8'd12,  8'd11,
		8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
		8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0
	};

	// Cosine over a full turn: the upper half mirrors the half-wave table.
	function automatic logic [7:0] fold_lookup(input logic [7:0] idx);
		logic [6:0] i;
		i = idx[7] ? ~idx[6:0] : idx[6:0];
		return HALF_WAVE[i];
	endfunction

	// floor(c * 80 / 255) by reciprocal: floor(v / 255) = (v + v/256 + 1) / 256
	// holds for every v up to 80 * 255.
	function automatic logic [LEVEL_W-1:0] level_scale(input logic [7:0] c);
		logic [15:0] v;
		logic [15:0] s;
		v = {2'b00, c, 6'b0} + {4'b0000, c, 4'b0};
		s = v + {8'h00, v[15:8]} + 16'd1;
		return s[14:8];
	endfunction

endpackage

// File: rtl/core/plasma_pixel_generator_core.sv
`timescale 1ns / 1ps
// Plasma pixel generator core.
//
// Input channel (in_valid / in_ready / in_data): each transfer is one request.
// A pixel request returns one result with the red, green and blue levels
// (0..80) of that coordinate. An advance-frame request moves every phase by
// its step minus four, a reload request copies the start phases in; neither
// returns a result. Request code 3 is dropped without effect.
// Output channel (out_valid / out_ready / out_data): one transfer per pixel.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is
// always ready; index 0 is the coordinate scale, 1 the start phases, 2 the
// phase steps, and index 3 is ignored. Write it only while the block is idle.
// Throughput: one request per cycle unless every rank is full; the five
// register ranks (input, three compute ranks, output) each hold one pixel.
// When the receiver stalls, the result holds on out_data and empty ranks
// upstream keep filling, so in_ready falls only once every rank is occupied.
// Reset clears all ranks, the phases to zero and the registers to defaults.

module plasma_pixel_generator_core
	import ppg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers and the running phases.
	logic [7:0]       scale_q;
	logic [CFG_W-1:0] start_q;
	logic [CFG_W-1:0] steps_q;
	phase_t           phase_q [NUM_PHASE];

	logic in_xfer;
	logic cfg_xfer;

	// Rank valid bits and the ready chain that lets bubbles collapse.
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic free1, free2, free3, free4, out_free;

	// Rank 1: the coordinate and a snapshot of the phases taken at transfer.
	logic [7:0] x_s1, y_s1;
	phase_t     pa_s1 [NUM_CHAN];
	phase_t     pb_s1 [NUM_CHAN];

	// Rank 2: scaled coordinates, first phase, and cosine of the second phase plus a quarter turn.
	logic [7:0] xs_s2, ys_s2;
	phase_t     pa_s2 [NUM_CHAN];
	logic [7:0] bb_s2 [NUM_CHAN];

	// Rank 3: the two inner lookups.
	logic [7:0] xs_s3;
	logic [7:0] aa_s3 [NUM_CHAN];
	logic [7:0] t2_s3 [NUM_CHAN];

	// Rank 4: the wrapped channel sum.
	logic [7:0] c_s4 [NUM_CHAN];

	out_t out_q;

	logic [15:0] xs_prod, ys_prod;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;

	assign out_free = ~out_valid_q | out_ready;
	assign free4    = ~v_s4 | out_free;
	assign free3    = ~v_s3 | free4;
	assign free2    = ~v_s2 | free3;
	assign free1    = ~v_s1 | free2;
	assign in_ready = free1;
	assign in_xfer  = in_valid & in_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign xs_prod = {8'h00, x_s1} * {8'h00, scale_q};
	assign ys_prod = {8'h00, y_s1} * {8'h00, scale_q};

	// Configuration writes; an index past the last register changes nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			start_q <= START_RESET;
			steps_q <= STEPS_RESET;
		end else if (cfg_xfer) begin
			case (cfg_index)
				CFG_COORD_SCALE: scale_q <= cfg_data[7:0];
				CFG_START_PHASE: start_q <= cfg_data;
				CFG_PHASE_STEPS: steps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Phase updates happen at the transfer of the frame or reload request, so
	// a pixel taken earlier already holds its own copy of the old phases.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PHASE; k++) begin
				phase_q[k] <= '0;
			end
		end else if (in_xfer) begin
			case (in_data.req_type)
				REQ_FRAME: begin
					for (int k = 0; k < NUM_PHASE; k++) begin
						phase_q[k] <= phase_q[k] + steps_q[8*k +: 8] - STEP_REST;
					end
				end
				REQ_RELOAD: begin
					for (int k = 0; k < NUM_PHASE; k++) begin
						phase_q[k] <= start_q[8*k +: 8];
					end
				end
				default: ;
			endcase
		end
	end

	// Valid bits of the ranks. Only pixel requests occupy a rank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free1) begin
				v_s1 <= in_xfer & (in_data.req_type == REQ_PIXEL);
			end
			if (free2) begin
				v_s2 <= v_s1;
			end
			if (free3) begin
				v_s3 <= v_s2;
			end
			if (free4) begin
				v_s4 <= v_s3;
			end
			if (out_free) begin
				out_valid_q <= v_s4;
			end
		end
	end

	// Datapath ranks; payload needs no reset.
	always_ff @(posedge clk) begin
		if (free1 && in_xfer) begin
			x_s1 <= in_data.pixel_x;
			y_s1 <= in_data.pixel_y;
			for (int k = 0; k < NUM_CHAN; k++) begin
				pa_s1[k] <= phase_q[2*k];
				pb_s1[k] <= phase_q[2*k+1];
			end
		end
		if (free2) begin
			xs_s2 <= xs_prod[7:0];
			ys_s2 <= ys_prod[7:0];
			for (int k = 0; k < NUM_CHAN; k++) begin
				pa_s2[k] <= pa_s1[k];
				bb_s2[k] <= fold_lookup(pb_s1[k] + QUARTER);
			end
		end
		if (free3) begin
			xs_s3 <= xs_s2;
			for (int k = 0; k < NUM_CHAN; k++) begin
				aa_s3[k] <= fold_lookup(ys_s2 + pa_s2[k]);
				t2_s3[k] <= fold_lookup(ys_s2 + bb_s2[k] + QUARTER);
			end
		end
		if (free4) begin
			for (int k = 0; k < NUM_CHAN; k++) begin
				c_s4[k] <= fold_lookup(xs_s3 + aa_s3[k]) + t2_s3[k];
			end
		end
		if (out_free) begin
			out_q.red_level   <= level_scale(c_s4[0]);
			out_q.green_level <= level_scale(c_s4[1]);
			out_q.blue_level  <= level_scale(c_s4[2]);
		end
	end

endmodule

// File: rtl/core/ppg_checker.sv
`timescale 1ns / 1ps

module ppg_checker
	import ppg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data,
	input logic cfg_valid,
	input logic cfg_ready
);

	// A stalled result stays presented and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// A waiting request stays presented and unchanged until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request changed or dropped while waiting");

	// Every level lies within the scaled range.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.red_level <= 7'd80 && out_data.green_level <= 7'd80
			&& out_data.blue_level <= 7'd80)
		else $error("level above 80");

	// With the output rank empty, every rank can move, so requests are taken.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// Configuration writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind plasma_pixel_generator_core ppg_checker u_ppg_checker (.*);
